// ----- rtl/core/mmeq_pkg.sv -----
// Types and constants shared by the MIDI event queue modules.
`timescale 1ns / 1ps

package mmeq_pkg;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 72;
	localparam int STAMP_W     = 32;

	// Upper nibble of the status byte for each channel message.
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_POLY_AT  = 4'hA;
	localparam logic [3:0] NIB_CC       = 4'hB;
	localparam logic [3:0] NIB_PROGRAM  = 4'hC;
	localparam logic [3:0] NIB_PRESSURE = 4'hD;
	localparam logic [3:0] NIB_BEND     = 4'hE;

	localparam logic [1:0] LEN_SHORT = 2'd2;
	localparam logic [1:0] LEN_FULL  = 2'd3;

	localparam logic [15:0] BEND_BIAS = 16'd8192;

	typedef enum logic [2:0] {
		RC_STORED  = 3'd0,
		RC_NOPARSE = 3'd1,
		RC_FULL    = 3'd2,
		RC_POPPED  = 3'd3,
		RC_EMPTY   = 3'd4
	} rc_t;

	typedef enum logic [2:0] {
		KIND_NOTE_ON  = 3'd0,
		KIND_NOTE_OFF = 3'd1,
		KIND_CC       = 3'd2,
		KIND_BEND     = 3'd3,
		KIND_PROGRAM  = 3'd4,
		KIND_POLY_AT  = 3'd5,
		KIND_PRESSURE = 3'd6
	} kind_t;

	// Stored event, kind in the lowest bits.
	typedef struct packed {
		logic [15:0] bend;
		logic [7:0]  second;
		logic [7:0]  first;
		logic [3:0]  channel;
		kind_t       kind;
	} event_t;

	localparam int EVENT_W = $bits(event_t);

	typedef struct packed {
		logic   ok;
		event_t evt;
	} dec_t;

endpackage

// ----- rtl/core/midi_message_event_queue_core.sv -----
// MIDI channel message decoder with an event FIFO held in block RAM.
// Path: an accepted request is registered in the s1 stage (result code and RAM read data), then
// moves to the output register when that register is empty or being taken.
// Throughput: one request per cycle while the s1 stage is not stalled; a pop reads the event
// and time RAMs in the accept cycle and the registered read data forms the result.
// Reset: both counters and all valid flags clear; RAM contents are not cleared.
`timescale 1ns / 1ps

module midi_message_event_queue_core
	import mmeq_pkg::*;
#(
	parameter int FIFO_DEPTH = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// status_byte, first_data, second_data, msg_length, stamp_in, zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// action
	input  logic [0:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// event_kind, channel_out, first_out, second_out, bend_out, stamp_out, zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// result_code
	output logic [2:0]             m_axis_tuser
);

	localparam int AW = $clog2(FIFO_DEPTH);

	logic [AW:0]          wr_cnt_q, rd_cnt_q, fill;
	logic                 full, empty;
	logic                 in_acc, is_pop, s1_adv;
	dec_t                 dec;
	rc_t                  code_in;
	logic                 ram_we, ram_re;
	logic                 valid_s1;
	rc_t                  code_s1;
	event_t               evt_rd;
	logic [STAMP_W-1:0]   stamp_rd;
	logic                 out_valid_q;
	rc_t                  out_code_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	mmeq_decode u_decode (
		.status_byte (s_axis_tdata[7:0]),
		.first_data  (s_axis_tdata[15:8]),
		.second_data (s_axis_tdata[23:16]),
		.msg_length  (s_axis_tdata[25:24]),
		.dec         (dec)
	);

	assign fill  = wr_cnt_q - rd_cnt_q;
	assign full  = fill[AW];
	assign empty = (wr_cnt_q == rd_cnt_q);

	assign is_pop        = s_axis_tuser[0];
	assign s1_adv        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		priority if (is_pop) begin
			code_in = empty ? RC_EMPTY : RC_POPPED;
		end else if (!dec.ok) begin
			code_in = RC_NOPARSE;
		end else if (full) begin
			code_in = RC_FULL;
		end else begin
			code_in = RC_STORED;
		end
	end

	assign ram_we = in_acc && !is_pop && (code_in == RC_STORED);
	assign ram_re = in_acc && (code_in == RC_POPPED);

	// Only one access per cycle, and a write lands before any later read of the entry.
	mmeq_ram #(.WIDTH(EVENT_W), .DEPTH(FIFO_DEPTH)) u_event_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_cnt_q[AW-1:0]),
		.wdata (dec.evt),
		.re    (ram_re),
		.raddr (rd_cnt_q[AW-1:0]),
		.rdata (evt_rd)
	);

	mmeq_ram #(.WIDTH(STAMP_W), .DEPTH(FIFO_DEPTH)) u_time_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_cnt_q[AW-1:0]),
		.wdata (s_axis_tdata[57:26]),
		.re    (ram_re),
		.raddr (rd_cnt_q[AW-1:0]),
		.rdata (stamp_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q <= '0;
			rd_cnt_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (ram_we) begin
				wr_cnt_q <= wr_cnt_q + 1'b1;
			end
			if (ram_re) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			code_s1 <= code_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_code_q <= code_s1;
			if (code_s1 == RC_POPPED) begin
				out_data_q <= {1'b0, stamp_rd, evt_rd};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_code_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= (AW+1)'(FIFO_DEPTH))
		else $error("event FIFO fill exceeds its depth");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |-> !s_axis_tready)
		else $error("request accepted while the result stage is stalled");

	a_store_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !is_pop && code_in == RC_STORED) |=>
			(wr_cnt_q == $past(wr_cnt_q) + 1'b1))
		else $error("stored event did not advance the write counter");

	a_pop_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> !empty)
		else $error("RAM read issued on an empty FIFO");

endmodule

// ----- rtl/core/mmeq_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module mmeq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// Read data holds while no read is issued.
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/mmeq_decode.sv -----
// Channel message decoder: classifies a message and packs it as an event.
`timescale 1ns / 1ps

module mmeq_decode
	import mmeq_pkg::*;
(
	input  logic [7:0] status_byte,
	input  logic [7:0] first_data,
	input  logic [7:0] second_data,
	input  logic [1:0] msg_length,
	output dec_t       dec
);

	logic [15:0] bend_raw;
	logic [1:0]  need;
	logic        known;

	assign bend_raw = (({8'd0, second_data} << 7) | {8'd0, first_data}) - BEND_BIAS;

	always_comb begin
		known          = 1'b1;
		need           = LEN_FULL;
		dec.evt.kind    = KIND_NOTE_ON;
		dec.evt.channel = status_byte[3:0];
		dec.evt.first   = first_data;
		dec.evt.second  = second_data;
		dec.evt.bend    = '0;
		unique case (status_byte[7:4])
			NIB_NOTE_ON: begin
				// A note on with zero velocity is a note off.
				dec.evt.kind = (second_data == 8'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
			end
			NIB_NOTE_OFF: dec.evt.kind = KIND_NOTE_OFF;
			NIB_CC:       dec.evt.kind = KIND_CC;
			NIB_POLY_AT:  dec.evt.kind = KIND_POLY_AT;
			NIB_BEND: begin
				dec.evt.kind   = KIND_BEND;
				dec.evt.first  = '0;
				dec.evt.second = '0;
				dec.evt.bend   = bend_raw;
			end
			NIB_PROGRAM: begin
				dec.evt.kind   = KIND_PROGRAM;
				dec.evt.second = '0;
				need           = LEN_SHORT;
			end
			NIB_PRESSURE: begin
				dec.evt.kind   = KIND_PRESSURE;
				dec.evt.second = '0;
				need           = LEN_SHORT;
			end
			default: known = 1'b0;
		endcase
		dec.ok = known && (msg_length != 2'd0) && (msg_length >= need);
	end

endmodule
